### rtl/core/tpfx_pkg.sv
// Package for the prefix tree block: sizes, request codes and word types.
// Depends on nothing; used by tpfx_store, trie_insert_search_prefix_top, tpfx_checker and tb_top.
package tpfx_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int COUNT_W  = $clog2(MAX_NODES + 1);
    localparam int SLOTS    = MAX_NODES * ALPHABET_SIZE;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int LETTER_W = 5;
    localparam int REQ_W    = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PREFIX = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } tpfx_req_t;

    typedef struct packed {
        logic               found;
        logic               pool_full;
        logic [COUNT_W-1:0] nodes_used;
    } tpfx_rsp_t;

    // A child slot holds the link and the end-of-word mark of the child node.
    typedef struct packed {
        logic              end_mark;
        logic [NODE_W-1:0] link;
    } tpfx_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        tpfx_entry_t       data;
    } tpfx_wr_t;

endpackage

### rtl/core/trie_insert_search_prefix_top.sv
// Top level of the prefix tree: letter walker, node allocator and result register.
// Depends on tpfx_pkg and tpfx_store.
//
// After reset the block sweeps its child slot memory to zero, one slot a cycle, over all
// MAX_NODES times ALPHABET_SIZE slots with busy high. After that each letter word is
// handled as a registered read of the cursor's child slot, issued on acceptance,
// then in ST_LOOKUP the allocation, write back and cursor move. The next letter cannot
// start until the cursor has moved, so busy is high for the cycle after each accepted
// word. On a last letter the result is worked out in ST_LOOKUP and registered, with
// done high for exactly one cycle; the receiver must take it then.
module trie_insert_search_prefix_top
    import tpfx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tpfx_req_t req,
    output logic      done,
    output tpfx_rsp_t result
);

    typedef enum logic {ST_IDLE, ST_LOOKUP} state_t;

    state_t             state_reg, state_next;
    logic [NODE_W-1:0]  cursor_reg, cursor_next;
    logic [COUNT_W-1:0] next_free_reg, next_free_next;
    logic               path_missing_reg, path_missing_next;
    logic               insert_aborted_reg, insert_aborted_next;
    logic [REQ_W-1:0]   op_reg;
    logic               last_reg;
    logic               oor_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               done_reg, done_next;
    tpfx_rsp_t          result_reg, result_next;

    logic               accept;
    logic               clearing;
    logic               letter_oor;
    logic [LETTER_W-1:0] letter_sel;
    logic [SLOT_W-1:0]  slot_addr;
    tpfx_entry_t        rd_data;
    tpfx_wr_t           wr;
    logic [NODE_W-1:0]  link_v;
    logic               alloc;
    logic               broken_out;
    logic               mark_set;

    tpfx_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (slot_addr),
        .rd_data  (rd_data),
        .wr       (wr),
        .clearing (clearing)
    );

    assign busy       = clearing || (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign letter_oor = (req.letter >= LETTER_W'(ALPHABET_SIZE));
    assign letter_sel = letter_oor ? '0 : req.letter;
    assign slot_addr  = SLOT_W'(SLOT_W'(cursor_reg) * SLOT_W'(ALPHABET_SIZE))
                        + SLOT_W'(letter_sel);

    always_comb
    begin
        state_next          = state_reg;
        cursor_next         = cursor_reg;
        next_free_next      = next_free_reg;
        path_missing_next   = path_missing_reg;
        insert_aborted_next = insert_aborted_reg;
        done_next           = 1'b0;
        result_next         = result_reg;
        link_v              = rd_data.link;
        alloc               = 1'b0;
        broken_out          = 1'b0;
        mark_set            = 1'b0;
        wr                  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
                if (!path_missing_reg && !insert_aborted_reg)
                begin
                    if (oor_reg)
                    begin
                        path_missing_next = 1'b1;
                    end
                    else if (rd_data.link == '0)
                    begin
                        if (op_reg != REQ_INSERT)
                        begin
                            path_missing_next = 1'b1;
                        end
                        else if (next_free_reg >= COUNT_W'(MAX_NODES))
                        begin
                            insert_aborted_next = 1'b1;
                        end
                        else
                        begin
                            link_v         = NODE_W'(next_free_reg);
                            next_free_next = next_free_reg + 1'b1;
                            alloc          = 1'b1;
                        end
                    end
                    if (!path_missing_next && !insert_aborted_next)
                    begin
                        cursor_next = link_v;
                    end
                end

                broken_out = path_missing_next || insert_aborted_next;
                mark_set   = last_reg && (op_reg == REQ_INSERT) && !broken_out;

                wr.en            = alloc || mark_set;
                wr.addr          = slot_reg;
                wr.data.link     = link_v;
                wr.data.end_mark = rd_data.end_mark || mark_set;

                if (last_reg)
                begin
                    done_next              = 1'b1;
                    result_next.nodes_used = next_free_next;
                    result_next.pool_full  = (op_reg == REQ_INSERT) && insert_aborted_next;
                    unique case (op_reg)
                        REQ_INSERT: result_next.found = !broken_out;
                        REQ_SEARCH: result_next.found = !broken_out && rd_data.end_mark;
                        REQ_PREFIX: result_next.found = !broken_out;
                        default:    result_next.found = !broken_out;
                    endcase
                    cursor_next         = '0;
                    path_missing_next   = 1'b0;
                    insert_aborted_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cursor_reg         <= '0;
            next_free_reg      <= COUNT_W'(1);
            path_missing_reg   <= 1'b0;
            insert_aborted_reg <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            cursor_reg         <= cursor_next;
            next_free_reg      <= next_free_next;
            path_missing_reg   <= path_missing_next;
            insert_aborted_reg <= insert_aborted_next;
            done_reg           <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            op_reg   <= req.req_type;
            last_reg <= req.last_letter;
            oor_reg  <= letter_oor;
            slot_reg <= slot_addr;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_LOOKUP)) else $error("result without lookup");
    a_write_only_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_LOOKUP)) else $error("slot write outside lookup");
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg >= COUNT_W'(1)) && (next_free_reg <= COUNT_W'(MAX_NODES)))
        else $error("node count out of range");
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.pool_full) |-> !result_reg.found)
        else $error("word reported stored and pool full");
    a_flags_clear_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!path_missing_reg && !insert_aborted_reg && (cursor_reg == '0)))
        else $error("walk state not reset after last letter");

endmodule

### rtl/core/tpfx_store.sv
// Child slot memory of the prefix tree with its clearing sweep after reset.
// Depends on tpfx_pkg.
module tpfx_store
    import tpfx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output tpfx_entry_t       rd_data,
    input  tpfx_wr_t          wr,
    output logic              clearing
);

    tpfx_entry_t       mem [SLOTS];
    tpfx_entry_t       rd_data_reg;
    logic              clr_active_reg;
    logic [SLOT_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == SLOT_W'(SLOTS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !wr.en) else $error("write during clearing sweep");
    a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !rd_en) else $error("read during clearing sweep");
    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (clr_addr_reg <= SLOT_W'(SLOTS - 1)))
        else $error("clearing address beyond memory");

endmodule

### bench/tpfx_checker.sv
// Result checker for the prefix tree block: keeps its own node table, works out the
// result of every last letter and compares it with what the block returns.
// Depends on tpfx_pkg.
module tpfx_checker
    import tpfx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  tpfx_req_t req,
    input  logic      done,
    input  tpfx_rsp_t result,
    output int        fail_count,
    output int        pending
);

    logic [NODE_W-1:0]  link_tab [0:SLOTS-1];
    logic               end_tab  [0:MAX_NODES-1];
    logic [NODE_W-1:0]  cursor;
    logic [COUNT_W-1:0] free_next;
    logic               lost_path;
    logic               gave_up;
    tpfx_rsp_t          owed_rsp [$];
    tpfx_rsp_t          want;
    tpfx_rsp_t          head;
    logic               emits;
    int                 misses = 0;
    int                 owed   = 0;

    assign fail_count = misses;
    assign pending    = owed;

    task automatic advance_trie(input tpfx_req_t w, output logic has_rsp,
                                output tpfx_rsp_t r);
        int                slot;
        logic [NODE_W-1:0] nxt;
        logic              broken;
        has_rsp = 1'b0;
        r       = '0;
        if (!lost_path && !gave_up)
        begin
            if (w.letter >= ALPHABET_SIZE)
            begin
                lost_path = 1'b1;
            end
            else
            begin
                slot = int'(cursor) * ALPHABET_SIZE + int'(w.letter);
                nxt  = link_tab[slot];
                if (nxt == '0)
                begin
                    if (w.req_type != REQ_INSERT)
                        lost_path = 1'b1;
                    else if (free_next >= MAX_NODES)
                        gave_up = 1'b1;
                    else
                    begin
                        nxt            = free_next[NODE_W-1:0];
                        link_tab[slot] = nxt;
                        free_next      = free_next + 1'b1;
                    end
                end
                if (!lost_path && !gave_up)
                    cursor = nxt;
            end
        end
        if (w.last_letter)
        begin
            has_rsp = 1'b1;
            broken  = lost_path || gave_up;
            if (w.req_type == REQ_INSERT)
            begin
                if (!broken)
                begin
                    end_tab[cursor] = 1'b1;
                    r.found         = 1'b1;
                end
                r.pool_full = gave_up;
            end
            else if (w.req_type == REQ_SEARCH)
            begin
                r.found = !broken && end_tab[cursor];
            end
            else
            begin
                r.found = !broken;
            end
            r.nodes_used = free_next;
            cursor       = '0;
            lost_path    = 1'b0;
            gave_up      = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                link_tab[i] = '0;
            for (int i = 0; i < MAX_NODES; i++)
                end_tab[i] = 1'b0;
            cursor    = '0;
            free_next = COUNT_W'(1);
            lost_path = 1'b0;
            gave_up   = 1'b0;
            owed_rsp.delete();
            owed      = 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_rsp.size() == 0)
                begin
                    misses++;
                    if (misses <= 10)
                        $display("unexpected result: found=%0d pool_full=%0d nodes_used=%0d",
                                 result.found, result.pool_full, result.nodes_used);
                end
                else
                begin
                    head = owed_rsp.pop_front();
                    owed--;
                    if (head.found !== result.found || head.pool_full !== result.pool_full
                        || head.nodes_used !== result.nodes_used)
                    begin
                        misses++;
                        if (misses <= 10)
                            $display({"mismatch: expected found=%0d pool_full=%0d ",
                                      "nodes_used=%0d, got found=%0d pool_full=%0d ",
                                      "nodes_used=%0d"},
                                     head.found, head.pool_full, head.nodes_used,
                                     result.found, result.pool_full, result.nodes_used);
                    end
                end
            end
            if (start && !busy)
            begin
                advance_trie(req, emits, want);
                if (emits)
                begin
                    owed_rsp.push_back(want);
                    owed++;
                end
            end
        end
    end

endmodule

### bench/tb_top.sv
// Testbench top for the prefix tree block: clock, reset, directed and random letters.
// Depends on tpfx_pkg, trie_insert_search_prefix_top and tpfx_checker.
module tb_top;
    import tpfx_pkg::*;

    localparam int ITEMS       = 2000;
    localparam int ITEM_CAP    = 6000;
    localparam int AFTER_FULL  = 150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int BANK_SIZE   = 128;
    localparam int WORD_MAX    = 12;

    localparam logic [REQ_W-1:0] REQ_ALIAS = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    tpfx_req_t           req;
    logic                done;
    tpfx_rsp_t           result;
    int                  mismatches;
    int                  outstanding;

    int                  idle_pct;
    int                  sent;
    int                  sent_full;
    logic                pool_hit = 1'b0;
    logic [LETTER_W-1:0] word_buf [0:WORD_MAX-1];
    int                  word_len;
    logic [LETTER_W-1:0] bank_ltr [0:BANK_SIZE-1][0:WORD_MAX-1];
    int                  bank_len [0:BANK_SIZE-1];
    int                  bank_n;

    trie_insert_search_prefix_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    tpfx_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .fail_count (mismatches),
        .pending    (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (done && result.pool_full)
            pool_hit <= 1'b1;
    end

    function automatic tpfx_req_t make_req(input logic [REQ_W-1:0] op,
                                           input logic [LETTER_W-1:0] ltr,
                                           input logic last);
        tpfx_req_t w;
        w.req_type    = op;
        w.letter      = ltr;
        w.last_letter = last;
        return w;
    endfunction

    task automatic put_letter(input logic [REQ_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                              input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            req   <= make_req(REQ_W'($urandom_range(3)), LETTER_W'($urandom_range(31)),
                              1'($urandom_range(1)));
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= make_req(op, ltr, last);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
        if (pool_hit)
            sent_full++;
    endtask

    task automatic send_buf(input logic [REQ_W-1:0] op);
        for (int i = 0; i < word_len; i++)
            put_letter(op, word_buf[i], i == word_len - 1);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic fresh_word();
        int hi;
        hi       = ($urandom_range(4) == 0) ? 2 : ALPHABET_SIZE - 1;
        word_len = $urandom_range(10, 1);
        for (int i = 0; i < word_len; i++)
            word_buf[i] = LETTER_W'($urandom_range(hi));
    endtask

    task automatic from_bank();
        int idx;
        int cut;
        if (bank_n == 0)
        begin
            fresh_word();
        end
        else
        begin
            idx      = $urandom_range(bank_n - 1);
            word_len = bank_len[idx];
            for (int i = 0; i < WORD_MAX; i++)
                word_buf[i] = bank_ltr[idx][i];
            cut = $urandom_range(9);
            if (cut < 2)
            begin
                word_len = $urandom_range(word_len, 1);
            end
            else if (cut == 2 && word_len < WORD_MAX)
            begin
                word_buf[word_len] = LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
                word_len++;
            end
        end
    endtask

    task automatic random_word();
        int pick;
        int slot;
        if ($urandom_range(99) < (pool_hit ? 20 : 60))
        begin
            fresh_word();
            send_buf(REQ_INSERT);
            if (bank_n < BANK_SIZE)
            begin
                slot = bank_n;
                bank_n++;
            end
            else
            begin
                slot = $urandom_range(BANK_SIZE - 1);
            end
            bank_len[slot] = word_len;
            for (int i = 0; i < WORD_MAX; i++)
                bank_ltr[slot][i] = word_buf[i];
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                from_bank();
                send_buf(REQ_SEARCH);
            end
            else if (pick < 60)
            begin
                from_bank();
                send_buf(pick[0] ? REQ_PREFIX : REQ_ALIAS);
            end
            else if (pick < 75)
            begin
                from_bank();
                send_buf(REQ_INSERT);
            end
            else if (pick < 87)
            begin
                fresh_word();
                send_buf(pick[0] ? REQ_SEARCH : REQ_PREFIX);
            end
            else
            begin
                word_len = $urandom_range(6, 1);
                for (int i = 0; i < word_len; i++)
                    put_letter(REQ_W'($urandom_range(3)),
                               LETTER_W'(($urandom_range(99) < 70) ?
                                         $urandom_range(ALPHABET_SIZE - 1) :
                                         $urandom_range(31, ALPHABET_SIZE)),
                               i == word_len - 1);
            end
        end
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = make_req(REQ_INSERT, '0, 1'b0);
        idle_pct  = 9;
        sent      = 0;
        sent_full = 0;
        bank_n    = 0;
        word_len  = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        put_letter(REQ_INSERT, 5'd0, 1'b1);
        put_letter(REQ_INSERT, 5'd25, 1'b1);
        put_letter(REQ_INSERT, 5'd25, 1'b0);
        put_letter(REQ_INSERT, 5'd0, 1'b1);
        put_letter(REQ_SEARCH, 5'd0, 1'b1);
        put_letter(REQ_SEARCH, 5'd25, 1'b1);
        put_letter(REQ_SEARCH, 5'd25, 1'b0);
        put_letter(REQ_SEARCH, 5'd1, 1'b1);
        put_letter(REQ_SEARCH, 5'd25, 1'b0);
        put_letter(REQ_SEARCH, 5'd0, 1'b0);
        put_letter(REQ_SEARCH, 5'd0, 1'b0);
        put_letter(REQ_SEARCH, 5'd3, 1'b1);
        put_letter(REQ_ALIAS, 5'd25, 1'b1);
        put_letter(REQ_PREFIX, 5'd24, 1'b1);
        put_letter(REQ_INSERT, 5'd31, 1'b0);
        put_letter(REQ_INSERT, 5'd0, 1'b1);
        put_letter(REQ_SEARCH, 5'd26, 1'b1);
        put_letter(REQ_INSERT, 5'd1, 1'b0);
        put_letter(REQ_SEARCH, 5'd2, 1'b1);
        put_letter(REQ_SEARCH, 5'd25, 1'b0);
        put_letter(REQ_INSERT, 5'd5, 1'b1);
        put_letter(REQ_SEARCH, 5'd25, 1'b0);
        put_letter(REQ_SEARCH, 5'd5, 1'b1);
        settle();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 9 : (phase == 1) ? 51 : 0;
            while (sent < (phase + 1) * ITEMS / 3
                   || (phase == 2 && (!pool_hit || sent_full < AFTER_FULL)
                       && sent < ITEM_CAP))
            begin
                random_word();
                if ($urandom_range(199) == 0)
                    settle();
            end
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
